FILE: design/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared constants and types for the pixel channel statistics block.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int COUNT_BITS     = 25;
    localparam int INDEX_BITS_DEF = 24;
    localparam int FIFO_DEPTH     = 4;
    localparam int NUM_STATS      = 25;
    localparam int WIDTH_BITS     = 16;
    localparam int EPS_BITS       = 31;
    localparam int Q_BITS         = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    // 100 * 65536, percentage in Q16.16
    localparam logic [22:0] PCT_SCALE = 23'd6553600;

    // configuration register indexes
    localparam logic CFG_IMAGE_WIDTH = 1'b0;
    localparam logic CFG_ZERO_EPS    = 1'b1;

    typedef enum logic [4:0] {
        ST_TOTAL, ST_FINITE, ST_ZERO, ST_FLAGS, ST_POS, ST_NEG, ST_NAN, ST_INF,
        ST_SUM, ST_AVG, ST_MIN, ST_MIN_IDX, ST_MAX, ST_MAX_IDX,
        ST_NZ_SUM, ST_NZ_AVG, ST_NZ_MIN, ST_NZ_MIN_IDX, ST_NZ_MAX, ST_NZ_MAX_IDX,
        ST_MIN_X, ST_MIN_Y, ST_MAX_X, ST_MAX_Y, ST_PCT
    } t_stat_id;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

FILE: design/pcs_div.sv
// ----------------------------------------------------------------------------
// pcs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcs_div #(
    parameter int NW = 24,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic          o_done,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   n_trial;
    logic          n_ge;

    assign n_trial = {r_rem, r_num[NW-1]};
    assign n_ge    = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[NW-2:0], n_ge};
                r_rem <= n_ge ? DW'(n_trial - {1'b0, r_den}) : DW'(n_trial);
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;
endmodule

FILE: design/pcs_fifo.sv
// ----------------------------------------------------------------------------
// pcs_fifo
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module pcs_fifo #(
    parameter int EW    = 88,
    parameter int DEPTH = pcs_pkg::FIFO_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [EW-1:0]        i_data,
    input  logic                 i_pop,
    output logic [EW-1:0]        o_data,
    output pcs_pkg::t_fifo_status o_status
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [EW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_data;
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_data         = r_mem[r_rd];
    assign o_status.full  = r_cnt == CW'(DEPTH);
    assign o_status.empty = r_cnt == '0;
endmodule

FILE: design/pcs_front.sv
// ----------------------------------------------------------------------------
// pcs_front
// Accepts requests, converts to Q16.16, classifies, splits index into x,y.
// ----------------------------------------------------------------------------
module pcs_front #(
    parameter int INDEX_BITS = pcs_pkg::INDEX_BITS_DEF,
    parameter int EW         = 4 + 32 + 16 + 2 * INDEX_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [31:0]                   i_value_bits,
    input  logic [INDEX_BITS-1:0]         i_index,
    input  logic [pcs_pkg::WIDTH_BITS-1:0] i_image_width,
    input  logic [pcs_pkg::EPS_BITS-1:0]  i_zero_eps,
    input  pcs_pkg::t_fifo_status         i_q_status,
    output logic                          o_push,
    output logic [EW-1:0]                 o_entry
);
    logic        n_neg, n_nan, n_inf, n_zero, n_sat, n_need_div, n_acc;
    logic [7:0]  n_ex;
    logic [23:0] n_mant;
    logic signed [9:0] n_sh;
    logic [9:0]  n_r;
    logic [31:0] n_m, n_lim, n_mag, n_q;
    logic        div_done;
    logic [INDEX_BITS-1:0] div_quo;
    logic [pcs_pkg::WIDTH_BITS-1:0] div_rem;

    logic        r_wait, r_ent_valid;
    logic        r_mode, r_nan, r_inf, r_zero;
    logic [31:0] r_q;
    logic [pcs_pkg::WIDTH_BITS-1:0] r_x;
    logic [INDEX_BITS-1:0] r_idx, r_y;

    always_comb begin
        n_ex   = i_value_bits[30:23];
        n_neg  = i_value_bits[31];
        n_mant = {n_ex != 8'd0, i_value_bits[22:0]};
        n_sh   = $signed({2'b00, (n_ex == 8'd0) ? 8'd1 : n_ex}) - 10'sd134;
        n_r    = 10'(-n_sh);
        n_sat  = n_sh >= 10'sd8;
        if (n_sh >= 10'sd0) begin
            n_m = {8'd0, n_mant} << n_sh[2:0];
        end else if (n_r >= 10'd32) begin
            n_m = '0;
        end else begin
            n_m = {8'd0, n_mant} >> n_r[4:0];
        end
        n_lim  = n_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        n_mag  = (n_sat || n_m > n_lim) ? n_lim : n_m;
        n_q    = n_neg ? 32'(-n_mag) : n_mag;
        n_nan  = (n_ex == 8'hFF) && (i_value_bits[22:0] != 23'd0);
        n_inf  = (n_ex == 8'hFF) && (i_value_bits[22:0] == 23'd0);
        n_zero = n_mag <= {1'b0, i_zero_eps};
        n_need_div = !i_mode && (n_ex != 8'hFF) && !n_zero && (i_image_width != '0);
    end

    assign o_push     = r_ent_valid && !i_q_status.full;
    assign o_in_stall = r_wait || (r_ent_valid && i_q_status.full);
    assign n_acc      = i_in_valid && !o_in_stall;

    pcs_div #(.NW(INDEX_BITS), .DW(pcs_pkg::WIDTH_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(n_acc && n_need_div),
        .i_num  (i_index),
        .i_den  (i_image_width),
        .o_busy (),
        .o_done (div_done),
        .o_quo  (div_quo),
        .o_rem  (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait      <= 1'b0;
            r_ent_valid <= 1'b0;
        end else begin
            if (n_acc) begin
                r_mode <= i_mode;
                r_nan  <= n_nan;
                r_inf  <= n_inf;
                r_zero <= n_zero;
                r_q    <= n_q;
                r_idx  <= i_index;
                r_x    <= '0;
                r_y    <= i_index;   // no division (zero width, or zero, NaN or infinite value): whole index is the row
                r_wait      <= n_need_div;
                r_ent_valid <= !n_need_div;
            end else if (div_done) begin
                r_x         <= div_rem;
                r_y         <= div_quo;
                r_wait      <= 1'b0;
                r_ent_valid <= 1'b1;
            end else if (o_push) begin
                r_ent_valid <= 1'b0;
            end
        end
    end

    assign o_entry = {r_mode, r_nan, r_inf, r_zero, r_q, r_x, r_idx, r_y};
endmodule

FILE: design/pcs_back.sv
// ----------------------------------------------------------------------------
// pcs_back
// Accumulates statistics and emits the readout run.
// ----------------------------------------------------------------------------
module pcs_back #(
    parameter int INDEX_BITS = pcs_pkg::INDEX_BITS_DEF,
    parameter int EW         = 4 + 32 + 16 + 2 * INDEX_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pcs_pkg::t_fifo_status i_q_status,
    input  logic [EW-1:0]         i_entry,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [4:0]            o_stat_id,
    output logic signed [63:0]    o_stat_value,
    output logic                  o_last
);
    localparam int CB = pcs_pkg::COUNT_BITS;
    localparam int XB = pcs_pkg::WIDTH_BITS;

    typedef enum logic [2:0] {S_IDLE, S_AVG_F, S_AVG_N, S_PCT_MUL, S_PCT_DIV, S_EMIT} t_state;

    // entry fields
    logic e_mode, e_nan, e_inf, e_zero;
    logic signed [31:0] e_q;
    logic [XB-1:0] e_x;
    logic [INDEX_BITS-1:0] e_idx, e_y;
    assign {e_mode, e_nan, e_inf, e_zero, e_q, e_x, e_idx, e_y} = i_entry;

    t_state r_state;
    logic [CB-1:0] r_total, r_finite, r_nan, r_inf, r_zero, r_pos, r_neg;
    logic signed [63:0] r_sum, r_nz_sum, r_avg_f, r_avg_n, r_pct;
    logic signed [31:0] r_ev [4];
    logic [INDEX_BITS-1:0] r_ei [4];
    logic [XB-1:0] r_bx [2];
    logic [INDEX_BITS-1:0] r_by [2];
    logic r_seen_f, r_seen_nz, r_issued;
    logic [47:0] r_prod;
    logic [4:0] r_id;
    logic r_out_valid;
    logic [4:0] r_out_id;
    logic signed [63:0] r_out_value;
    logic r_out_last;

    logic [CB:0] n_nz;
    logic n_load;
    logic signed [63:0] n_val;
    logic div_start, div_done;
    logic [63:0] div_num, div_quo;
    logic [CB-1:0] div_den;
    logic signed [63:0] n_sel_sum;

    assign n_nz   = {1'b0, r_pos} + {1'b0, r_neg};
    assign o_pop  = (r_state == S_IDLE) && !i_q_status.empty;
    assign n_load = !r_out_valid || !i_out_stall;

    // divider operand selection
    always_comb begin
        n_sel_sum = (r_state == S_AVG_F) ? r_sum : r_nz_sum;
        div_num   = n_sel_sum[63] ? 64'(-n_sel_sum) : n_sel_sum;
        div_den   = (r_state == S_AVG_F) ? r_finite : CB'(n_nz);
        div_start = 1'b0;
        case (r_state)
            S_AVG_F:   div_start = !r_issued && (r_finite != '0);
            S_AVG_N:   div_start = !r_issued && (n_nz != '0);
            S_PCT_DIV: begin
                div_start = !r_issued && (r_total != '0);
                div_num   = 64'(r_prod);
                div_den   = r_total;
            end
            default:   div_start = 1'b0;
        endcase
    end

    pcs_div #(.NW(64), .DW(CB)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_busy (),
        .o_done (div_done),
        .o_quo  (div_quo),
        .o_rem  ()
    );

    // statistic selection
    always_comb begin
        case (pcs_pkg::t_stat_id'(r_id))
            pcs_pkg::ST_TOTAL:      n_val = 64'(r_total);
            pcs_pkg::ST_FINITE:     n_val = 64'(r_finite);
            pcs_pkg::ST_ZERO:       n_val = 64'(r_zero);
            pcs_pkg::ST_FLAGS:      n_val = 64'({r_seen_nz, r_seen_f});
            pcs_pkg::ST_POS:        n_val = 64'(r_pos);
            pcs_pkg::ST_NEG:        n_val = 64'(r_neg);
            pcs_pkg::ST_NAN:        n_val = 64'(r_nan);
            pcs_pkg::ST_INF:        n_val = 64'(r_inf);
            pcs_pkg::ST_SUM:        n_val = r_sum;
            pcs_pkg::ST_AVG:        n_val = r_avg_f;
            pcs_pkg::ST_MIN:        n_val = 64'(r_ev[0]);
            pcs_pkg::ST_MIN_IDX:    n_val = 64'(r_ei[0]);
            pcs_pkg::ST_MAX:        n_val = 64'(r_ev[1]);
            pcs_pkg::ST_MAX_IDX:    n_val = 64'(r_ei[1]);
            pcs_pkg::ST_NZ_SUM:     n_val = r_nz_sum;
            pcs_pkg::ST_NZ_AVG:     n_val = r_avg_n;
            pcs_pkg::ST_NZ_MIN:     n_val = 64'(r_ev[2]);
            pcs_pkg::ST_NZ_MIN_IDX: n_val = 64'(r_ei[2]);
            pcs_pkg::ST_NZ_MAX:     n_val = 64'(r_ev[3]);
            pcs_pkg::ST_NZ_MAX_IDX: n_val = 64'(r_ei[3]);
            pcs_pkg::ST_MIN_X:      n_val = 64'(r_bx[0]);
            pcs_pkg::ST_MIN_Y:      n_val = 64'(r_by[0]);
            pcs_pkg::ST_MAX_X:      n_val = 64'(r_bx[1]);
            pcs_pkg::ST_MAX_Y:      n_val = 64'(r_by[1]);
            pcs_pkg::ST_PCT:        n_val = r_pct;
            default:                n_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (r_state == S_EMIT && n_load && r_id == 5'(pcs_pkg::ST_PCT))) begin
            r_total <= '0; r_finite <= '0; r_nan <= '0; r_inf <= '0;
            r_zero <= '0; r_pos <= '0; r_neg <= '0;
            r_sum <= '0; r_nz_sum <= '0;
            r_seen_f <= 1'b0; r_seen_nz <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_ev[i] <= '0;
                r_ei[i] <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                r_bx[i] <= '0;
                r_by[i] <= '0;
            end
        end else if (o_pop && !e_mode && r_total != pcs_pkg::COUNT_MAX) begin
            r_total <= r_total + 1'b1;
            if (e_nan) begin
                r_nan <= r_nan + 1'b1;
            end else if (e_inf) begin
                r_inf <= r_inf + 1'b1;
            end else begin
                r_finite <= r_finite + 1'b1;
                r_sum    <= r_sum + 64'(e_q);
                r_seen_f <= 1'b1;
                if (!r_seen_f || e_q < r_ev[0]) begin
                    r_ev[0] <= e_q; r_ei[0] <= e_idx;
                end
                if (!r_seen_f || e_q > r_ev[1]) begin
                    r_ev[1] <= e_q; r_ei[1] <= e_idx;
                end
                if (e_zero) begin
                    r_zero <= r_zero + 1'b1;
                end else begin
                    r_nz_sum <= r_nz_sum + 64'(e_q);
                    if (e_q > 0) r_pos <= r_pos + 1'b1;
                    else r_neg <= r_neg + 1'b1;
                    r_seen_nz <= 1'b1;
                    if (!r_seen_nz || e_q < r_ev[2]) begin
                        r_ev[2] <= e_q; r_ei[2] <= e_idx;
                    end
                    if (!r_seen_nz || e_q > r_ev[3]) begin
                        r_ev[3] <= e_q; r_ei[3] <= e_idx;
                    end
                    if (!r_seen_nz || e_x < r_bx[0]) r_bx[0] <= e_x;
                    if (!r_seen_nz || e_x > r_bx[1]) r_bx[1] <= e_x;
                    if (!r_seen_nz || e_y < r_by[0]) r_by[0] <= e_y;
                    if (!r_seen_nz || e_y > r_by[1]) r_by[1] <= e_y;
                end
            end
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_id        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (div_start) r_issued <= 1'b1;
            case (r_state)
                S_IDLE: begin
                    if (o_pop && e_mode) r_state <= S_AVG_F;
                end
                S_AVG_F: begin
                    if (!r_issued && r_finite == '0) begin
                        r_avg_f <= '0;
                        r_state <= S_AVG_N;
                    end else if (div_done) begin
                        r_avg_f  <= r_sum[63] ? 64'(-div_quo) : div_quo;
                        r_issued <= 1'b0;
                        r_state  <= S_AVG_N;
                    end
                end
                S_AVG_N: begin
                    if (!r_issued && n_nz == '0) begin
                        r_avg_n <= '0;
                        r_state <= S_PCT_MUL;
                    end else if (div_done) begin
                        r_avg_n  <= r_nz_sum[63] ? 64'(-div_quo) : div_quo;
                        r_issued <= 1'b0;
                        r_state  <= S_PCT_MUL;
                    end
                end
                S_PCT_MUL: begin
                    r_prod  <= 48'(n_nz) * 48'(pcs_pkg::PCT_SCALE);
                    r_state <= S_PCT_DIV;
                end
                S_PCT_DIV: begin
                    if (!r_issued && r_total == '0) begin
                        r_pct   <= '0;
                        r_id    <= '0;
                        r_state <= S_EMIT;
                    end else if (div_done) begin
                        r_pct    <= div_quo;
                        r_issued <= 1'b0;
                        r_id     <= '0;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (n_load) begin
                        r_out_valid <= 1'b1;
                        r_out_id    <= r_id;
                        r_out_value <= n_val;
                        r_out_last  <= r_id == 5'(pcs_pkg::ST_PCT);
                        r_id        <= r_id + 1'b1;
                        if (r_id == 5'(pcs_pkg::ST_PCT)) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_stat_id    = r_out_id;
    assign o_stat_value = r_out_value;
    assign o_last       = r_out_last;
endmodule

FILE: design/pixel_channel_statistics_top.sv
// ----------------------------------------------------------------------------
// pixel_channel_statistics_top
// Per-channel sample statistics over binary32 samples with pixel indices.
// ----------------------------------------------------------------------------
// Input channel: valid/stall. mode 0 adds one sample (value_bits, pixel_index);
//   mode 1 requests a readout of all statistics and then clears the store.
// Output channel: valid/stall, 25 results per readout (stat_id 0..24),
//   last set on the percentage, which is the final one.
// Configuration: write enable, index and data; write only while idle.
// Samples: a zero, NaN or infinite value, or a zero image width, needs no
//   division; any other sample stalls the input until the serial divider
//   has split the index into x and y. The front part keeps running
//   ahead of the back part through a four-entry queue.
// Readout: the two averages and the percentage are computed in turn on one
//   shared 64-bit serial divider, then one result a cycle unless stalled.
// When the receiver stalls, the current result holds in the output register
//   and the sequencer waits; queued requests keep waiting in the queue.
// Reset: synchronous, active low; clears the store, width 1, epsilon 0.
// ----------------------------------------------------------------------------
module pixel_channel_statistics_top #(
    parameter int INDEX_BITS = pcs_pkg::INDEX_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_in_mode,
    input  logic [31:0]        i_in_value_bits,
    input  logic [23:0]        i_in_pixel_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [4:0]         o_out_stat_id,
    output logic signed [63:0] o_out_stat_value,
    output logic               o_out_last,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [30:0]        i_cfg_data
);
    localparam int EW = 4 + pcs_pkg::Q_BITS + pcs_pkg::WIDTH_BITS + 2 * INDEX_BITS;

    logic [pcs_pkg::WIDTH_BITS-1:0] r_image_width;
    logic [pcs_pkg::EPS_BITS-1:0]   r_zero_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= pcs_pkg::WIDTH_BITS'(1);
            r_zero_eps    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pcs_pkg::CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data[15:0];
                pcs_pkg::CFG_ZERO_EPS:    r_zero_eps    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pcs_pkg::t_fifo_status q_status;
    logic          q_push, q_pop;
    logic [EW-1:0] q_in, q_out;

    pcs_front #(.INDEX_BITS(INDEX_BITS), .EW(EW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_in_mode),
        .i_value_bits (i_in_value_bits),
        .i_index      (INDEX_BITS'(i_in_pixel_index)),
        .i_image_width(r_image_width),
        .i_zero_eps   (r_zero_eps),
        .i_q_status   (q_status),
        .o_push       (q_push),
        .o_entry      (q_in)
    );

    pcs_fifo #(.EW(EW), .DEPTH(pcs_pkg::FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_status(q_status)
    );

    pcs_back #(.INDEX_BITS(INDEX_BITS), .EW(EW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_entry     (q_out),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_stat_id   (o_out_stat_id),
        .o_stat_value(o_out_stat_value),
        .o_last      (o_out_last)
    );

    // queue never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full) else $error("queue overflow");

    // last only on the final statistic
    a_last_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_last |-> o_out_stat_id == 5'(pcs_pkg::ST_PCT))
        else $error("last on wrong statistic");

    // a readout run is gapless and counts up
    a_run_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_last
        |=> o_out_valid && o_out_stat_id == $past(o_out_stat_id) + 5'd1)
        else $error("readout run broken");
endmodule
